// ----- src/pihx_pkg.sv -----
// Shared types, constants and the hex digit helper for the packed-to-HEX encoder.
// Used by every module in src; depends on nothing.
`default_nettype none

package pihx_pkg;

  // Data bytes per HEX record before a forced flush.
  localparam int REC_BYTES = 26;
  localparam int FILL_W    = $clog2(REC_BYTES + 1);
  // Pair counter covers header, data and checksum pairs: 6 + fill pairs.
  localparam int PAIR_W    = $clog2(REC_BYTES + 6);
  // Second tap of the record shift line (only read when a record has two or more bytes).
  localparam int NEXT_TAP  = (REC_BYTES > 1) ? 1 : 0;
  // A record flushed by an address jump ends the beat group unless the new byte fills again.
  localparam bit JUMP_LAST = (REC_BYTES != 1);

  localparam int END_PAIRS = 6;
  localparam int END_W     = $clog2(END_PAIRS);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPA   = 7'h41;
  localparam logic [6:0] CH_NL    = 7'h0A;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA
  } phase_t;

  typedef enum logic {
    CMD_DATA,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STORE,
    BK_REC,
    BK_END
  } back_state_t;

  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_STORE,
    AFT_END
  } after_t;

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) c = CH_ZERO + 7'(v);
    else           c = CH_UPA + 7'(v - 4'd10);
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/pihx_front.sv -----
// Front end: parses the packed byte stream and turns it into queue commands.
// Depends on pihx_pkg.
`default_nettype none

module pihx_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire logic                  op,
  input  wire logic [7:0]            data_byte,
  input  wire pihx_pkg::cmdq_status_t q_status,
  output logic                       push,
  output pihx_pkg::cmd_t             push_cmd
);
  import pihx_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] load_address, load_address_next;
  logic        accept;

  assign byte_stall = q_status.full;
  assign accept     = byte_valid && !q_status.full;

  // next state
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    load_address_next = load_address;
    if (accept) begin
      if (op == OP_END) begin
        phase_next      = PH_COUNT;
        bytes_left_next = 8'd0;
      end else begin
        unique case (phase)
          PH_COUNT: begin
            if (data_byte == 8'd0) begin
              bytes_left_next = 8'd0;
            end else begin
              bytes_left_next = data_byte;
              phase_next      = PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            load_address_next = {data_byte, 8'h00};
            phase_next        = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            load_address_next = {load_address[15:8], data_byte};
            phase_next        = PH_DATA;
          end
          PH_DATA: begin
            load_address_next = load_address + 16'd1;
            if (bytes_left != 8'd0) bytes_left_next = bytes_left - 8'd1;
            if (bytes_left <= 8'd1) phase_next = PH_COUNT;
          end
        endcase
      end
    end
  end

  // command out
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_FINISH;
    push_cmd.data = data_byte;
    push_cmd.addr = load_address;
    if (accept) begin
      if (op == OP_END) begin
        push = 1'b1;
      end else begin
        unique case (phase)
          PH_COUNT:   push = (data_byte == 8'd0);
          PH_ADDR_HI: push = 1'b0;
          PH_ADDR_LO: push = 1'b0;
          PH_DATA: begin
            push          = 1'b1;
            push_cmd.kind = CMD_DATA;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      bytes_left   <= 8'd0;
      load_address <= 16'd0;
    end else begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      load_address <= load_address_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/pihx_cmdq.sv -----
// Short command queue between the parser and the text sequencer.
// Depends on pihx_pkg.
`default_nettype none

module pihx_cmdq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire pihx_pkg::cmd_t        push_cmd,
  input  wire logic                  pop,
  output pihx_pkg::cmd_t             head,
  output pihx_pkg::cmdq_status_t     status
);
  import pihx_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_AW:0]   count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (CMDQ_AW+1)'(push) - (CMDQ_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/pihx_back.sv -----
// Back end: gathers data bytes into the held record and streams HEX text pairs.
// Depends on pihx_pkg.
`default_nettype none

module pihx_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pihx_pkg::cmdq_status_t q_status,
  input  wire pihx_pkg::cmd_t        head,
  output logic                       pop,
  output logic                       pair_valid,
  input  wire logic                  pair_stall,
  output logic [6:0]                 first_char,
  output logic [6:0]                 second_char,
  output logic                       last
);
  import pihx_pkg::*;

  back_state_t       state, state_next;
  after_t            after, after_next;
  logic              rec_last, rec_last_next;
  logic [FILL_W-1:0] fill;
  logic [15:0]       rec_start;
  logic [15:0]       next_addr;
  logic [7:0]        dsum;
  logic [PAIR_W-1:0] pc;
  logic [END_W-1:0]  ecnt;
  cmd_t              pend;
  logic [7:0]        rec_buf [REC_BYTES];

  logic              load_ok, emit, advance, do_store, shift_en;
  cmd_t              src;
  logic              jump, full_after, rec_tail, chk_pair, end_tail;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        fill8, total, chk;
  logic [6:0]        gen_first, gen_second;
  logic              gen_last;

  assign load_ok    = !pair_valid || !pair_stall;
  assign src        = (state == BK_STORE) ? pend : head;
  assign jump       = (fill != '0) && (head.addr != next_addr);
  assign fill_inc   = fill + 1'b1;
  assign full_after = (fill_inc == FILL_W'(REC_BYTES));
  assign fill8      = 8'(fill);
  assign total      = fill8 + rec_start[15:8] + rec_start[7:0] + dsum;
  assign chk        = 8'd0 - total;
  assign rec_tail   = (pc == PAIR_W'(fill) + PAIR_W'(5));
  assign chk_pair   = (pc == PAIR_W'(fill) + PAIR_W'(4));
  assign end_tail   = (ecnt == END_W'(END_PAIRS - 1));
  assign advance    = emit && load_ok;

  // next state
  always_comb begin
    state_next    = state;
    after_next    = after;
    rec_last_next = rec_last;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == CMD_FINISH) begin
            if (fill != '0) begin
              state_next    = BK_REC;
              after_next    = AFT_END;
              rec_last_next = 1'b0;
            end else begin
              state_next = BK_END;
            end
          end else if (jump) begin
            state_next    = BK_REC;
            after_next    = AFT_STORE;
            rec_last_next = JUMP_LAST;
          end else if (full_after) begin
            state_next    = BK_REC;
            after_next    = AFT_NONE;
            rec_last_next = 1'b1;
          end
        end
      end
      BK_STORE: begin
        if (full_after) begin
          state_next    = BK_REC;
          after_next    = AFT_NONE;
          rec_last_next = 1'b1;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_REC: begin
        if (load_ok && rec_tail) begin
          case (after)
            AFT_STORE: state_next = BK_STORE;
            AFT_END:   state_next = BK_END;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_END: begin
        if (load_ok && end_tail) state_next = BK_IDLE;
      end
    endcase
  end

  // outputs: queue pop, byte store and the next text pair
  always_comb begin
    pop        = 1'b0;
    do_store   = 1'b0;
    emit       = 1'b0;
    shift_en   = 1'b0;
    gen_first  = CH_ZERO;
    gen_second = CH_ZERO;
    gen_last   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop      = !q_status.empty;
        do_store = !q_status.empty && (head.kind == CMD_DATA) && !jump;
      end
      BK_STORE: do_store = 1'b1;
      BK_REC: begin
        emit = 1'b1;
        if (rec_tail) begin
          gen_first  = hex_char(chk[3:0]);
          gen_second = CH_NL;
          gen_last   = rec_last;
        end else if (chk_pair) begin
          gen_first  = hex_char(rec_buf[0][3:0]);
          gen_second = hex_char(chk[7:4]);
        end else begin
          case (pc)
            PAIR_W'(0): begin
              gen_first  = CH_COLON;
              gen_second = hex_char(fill8[7:4]);
            end
            PAIR_W'(1): begin
              gen_first  = hex_char(fill8[3:0]);
              gen_second = hex_char(rec_start[15:12]);
            end
            PAIR_W'(2): begin
              gen_first  = hex_char(rec_start[11:8]);
              gen_second = hex_char(rec_start[7:4]);
            end
            PAIR_W'(3): begin
              gen_first  = hex_char(rec_start[3:0]);
              gen_second = CH_ZERO;
            end
            PAIR_W'(4): begin
              gen_first  = CH_ZERO;
              gen_second = hex_char(rec_buf[0][7:4]);
            end
            default: begin
              // low nibble of this byte, high nibble of the next; then advance the line
              gen_first  = hex_char(rec_buf[0][3:0]);
              gen_second = hex_char(rec_buf[NEXT_TAP][7:4]);
              shift_en   = load_ok;
            end
          endcase
        end
      end
      BK_END: begin
        emit = 1'b1;
        if (ecnt == '0) begin
          gen_first = CH_COLON;
        end else if (end_tail) begin
          gen_second = CH_NL;
          gen_last   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      after      <= AFT_NONE;
      rec_last   <= 1'b0;
      fill       <= '0;
      rec_start  <= 16'd0;
      next_addr  <= 16'd0;
      dsum       <= 8'd0;
      pc         <= '0;
      ecnt       <= '0;
      pair_valid <= 1'b0;
    end else begin
      state    <= state_next;
      after    <= after_next;
      rec_last <= rec_last_next;
      if (do_store) begin
        fill      <= fill_inc;
        next_addr <= src.addr + 16'd1;
        if (fill == '0) begin
          rec_start <= src.addr;
          dsum      <= src.data;
        end else begin
          dsum <= dsum + src.data;
        end
      end
      if (advance && state == BK_REC) begin
        if (rec_tail) begin
          pc   <= '0;
          fill <= '0;
        end else begin
          pc <= pc + 1'b1;
        end
      end
      if (advance && state == BK_END) begin
        ecnt <= end_tail ? '0 : ecnt + 1'b1;
      end
      if (load_ok) pair_valid <= emit;
    end
  end

  // payload: pending command, record line and output pair
  always_ff @(posedge clk) begin
    if (pop) pend <= head;
    if (shift_en) begin
      for (int i = 0; i < REC_BYTES - 1; i++) rec_buf[i] <= rec_buf[i+1];
    end else if (do_store) begin
      for (int i = 0; i < REC_BYTES; i++) begin
        if (fill == FILL_W'(i)) rec_buf[i] <= src.data;
      end
    end
    if (load_ok && emit) begin
      first_char  <= gen_first;
      second_char <= gen_second;
      last        <= gen_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/packed_to_intel_hex_encoder.sv -----
// Top level of the packed-record to Intel HEX encoder.
// Instantiates pihx_front, pihx_cmdq and pihx_back; depends on pihx_pkg.
//
// Each input beat is one packed byte (op = 0) or an end-of-input mark (op = 1).
// The parser classifies beats at one per cycle unless the queue is full;
// nonzero count and address bytes cause no output; data bytes, zero count
// bytes and end marks become commands in a four-entry queue. The back end
// takes one queued command per cycle and adds a data byte to the held record.
// When a record is sent (full at 26 bytes, address jump, zero count byte or
// end of input) it streams one character pair per cycle while pair_stall is
// low: 6 + n pairs for n data bytes, then 6 pairs for the end record where
// the stream ends. The single pair-wide output sequencer sets the rate and
// takes no command during a record. Output pairs leave through a register,
// so the next pair is prepared while the current one waits on pair_stall.
// The last output is set on the final pair that a given input beat causes.
`default_nettype none

module packed_to_intel_hex_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output logic            pair_valid,
  input  wire logic       pair_stall,
  output logic [6:0]      first_char,
  output logic [6:0]      second_char,
  output logic            last
);
  import pihx_pkg::*;

  cmdq_status_t q_status;
  cmd_t         push_cmd, head;
  logic         q_push, q_pop;

  // Parse packed bytes; push data and finish commands.
  pihx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .op         (op),
    .data_byte  (data_byte),
    .q_status   (q_status),
    .push       (q_push),
    .push_cmd   (push_cmd)
  );

  // Decouple parsing from text generation.
  pihx_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .status   (q_status)
  );

  // Gather bytes into records and stream the text.
  pihx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (q_pop),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .first_char  (first_char),
    .second_char (second_char),
    .last        (last)
  );

  // Never push into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_push)
    else $error("command pushed into full queue");

  // Never pop an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !q_pop)
    else $error("command popped from empty queue");

  // Queue flags are exclusive.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty");

endmodule

`default_nettype wire

// ----- dv/packed_to_intel_hex_encoder_tb.sv -----
// Self-checking bench for packed_to_intel_hex_encoder: directed and random packed-record beats.
// A scoreboard class predicts every HEX character pair; needs pihx_pkg and the encoder RTL.
`timescale 1ns / 100ps

module packed_to_intel_hex_encoder_tb;
  import pihx_pkg::*;

  // Stop after this many consecutive cycles in which neither side moves a beat.
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BEATS = 130;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [6:0] c_first;
    logic [6:0] c_second;
    logic       is_last;
  } char_pair_t;

  // Predicts the HEX text for each input beat and checks the pairs that leave the block.
  class hex_scoreboard;
    phase_t      phase;
    logic [7:0]  bytes_left;
    logic [15:0] load_addr;
    logic [15:0] next_addr;
    logic [15:0] rec_start;
    logic [7:0]  rec_data [REC_BYTES];
    int          fill;
    logic [6:0]  line [$];
    char_pair_t  expected_pairs [$];
    int          failures;
    int          beats_taken;
    int          pairs_checked;
    int          data_records;
    int          end_records;

    function new();
      phase         = PH_COUNT;
      bytes_left    = 8'd0;
      load_addr     = 16'd0;
      next_addr     = 16'd0;
      rec_start     = 16'd0;
      fill          = 0;
      failures      = 0;
      beats_taken   = 0;
      pairs_checked = 0;
      data_records  = 0;
      end_records   = 0;
    endfunction

    function logic [6:0] nibble_char(logic [3:0] v);
      return (v < 4'd10) ? CH_ZERO + 7'(v) : CH_UPA - 7'd10 + 7'(v);
    endfunction

    function void put_byte(logic [7:0] b);
      line.push_back(nibble_char(b[7:4]));
      line.push_back(nibble_char(b[3:0]));
    endfunction

    // Emit the held data record, if any, and empty it.
    function void flush_record();
      logic [7:0] sum;
      if (fill == 0) return;
      sum = 8'(fill) + rec_start[15:8] + rec_start[7:0];
      line.push_back(CH_COLON);
      put_byte(8'(fill));
      put_byte(rec_start[15:8]);
      put_byte(rec_start[7:0]);
      put_byte(8'h00);
      for (int i = 0; i < fill; i++) begin
        put_byte(rec_data[i]);
        sum += rec_data[i];
      end
      put_byte(8'h00 - sum);
      line.push_back(CH_NL);
      fill = 0;
      data_records++;
    endfunction

    function void finish_stream();
      flush_record();
      line.push_back(CH_COLON);
      repeat (10) line.push_back(CH_ZERO);
      line.push_back(CH_NL);
      phase      = PH_COUNT;
      bytes_left = 8'd0;
      end_records++;
    endfunction

    function void add_data(logic [7:0] b);
      if (fill != 0 && load_addr != next_addr) flush_record();
      if (fill == 0) rec_start = load_addr;
      rec_data[fill] = b;
      fill++;
      next_addr = load_addr + 16'd1;
      if (fill >= REC_BYTES) flush_record();
    endfunction

    // Record one accepted input beat and queue the pairs it must produce.
    function void note_beat(logic o, logic [7:0] b);
      int n;
      beats_taken++;
      line.delete();
      if (o == OP_END) begin
        finish_stream();
      end else begin
        case (phase)
          PH_COUNT: begin
            if (b == 8'd0) begin
              finish_stream();
            end else begin
              bytes_left = b;
              phase      = PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            load_addr = {b, 8'h00};
            phase     = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            load_addr = {load_addr[15:8], b};
            phase     = PH_DATA;
          end
          default: begin
            add_data(b);
            load_addr = load_addr + 16'd1;
            if (bytes_left != 8'd0) bytes_left--;
            if (bytes_left == 8'd0) phase = PH_COUNT;
          end
        endcase
      end
      n = line.size() / 2;
      for (int k = 0; k < n; k++) begin
        expected_pairs.push_back('{line[2*k], line[2*k+1], k == n - 1});
      end
    endfunction

    function void check_pair(logic [6:0] c0, logic [6:0] c1, logic l);
      char_pair_t want;
      pairs_checked++;
      if (expected_pairs.size() == 0) begin
        $error("unexpected pair: first_char %h second_char %h last %b", c0, c1, l);
        failures++;
        return;
      end
      want = expected_pairs.pop_front();
      if (c0 !== want.c_first) begin
        $error("first_char: expected %h, got %h", want.c_first, c0);
        failures++;
      end
      if (c1 !== want.c_second) begin
        $error("second_char: expected %h, got %h", want.c_second, c1);
        failures++;
      end
      if (l !== want.is_last) begin
        $error("last: expected %b, got %b", want.is_last, l);
        failures++;
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       byte_valid = 1'b0;
  logic       op         = OP_BYTE;
  logic [7:0] data_byte  = 8'h00;
  logic       pair_stall = 1'b0;
  logic       byte_stall;
  logic       pair_valid;
  logic [6:0] first_char;
  logic [6:0] second_char;
  logic       last;

  // No random idling on either side while this is set.
  bit             quiet_stretch = 1'b0;
  int             idle_cycles   = 0;
  hex_scoreboard  sb;

  packed_to_intel_hex_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .op          (op),
    .data_byte   (data_byte),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .first_char  (first_char),
    .second_char (second_char),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output side: stall about a third of the time, except in the quiet stretch.
  always @(negedge clk) begin
    pair_stall <= !quiet_stretch && ($urandom_range(0, 99) < 34);
  end

  // Check every pair that leaves the block.
  always @(posedge clk) begin
    if (!rst && pair_valid && !pair_stall) sb.check_pair(first_char, second_char, last);
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (pair_valid && !pair_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one beat. Enter and leave at a falling edge; valid stays high on return,
  // so the next call or a pause decides what happens in that step.
  task automatic send_beat(input logic o, input logic [7:0] b);
    while (!quiet_stretch && $urandom_range(0, 99) < 34) begin
      byte_valid <= 1'b0;
      op         <= 1'($urandom_range(0, 1));
      data_byte  <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    op         <= o;
    data_byte  <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_beat(o, b);
    @(negedge clk);
  endtask

  // Hold the input off until every predicted pair has come out.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Send a packed record of cnt random data bytes at addr. A nonzero cut stops
  // after that many beats of the record and sends an end mark instead.
  task automatic send_packed(input logic [7:0] cnt, input logic [15:0] addr, input int cut);
    int total;
    logic [7:0] b;
    total = int'(cnt) + 3;
    for (int i = 0; i < total; i++) begin
      if (cut != 0 && i == cut) break;
      case (i)
        0:       b = cnt;
        1:       b = addr[15:8];
        2:       b = addr[7:0];
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_beat(OP_BYTE, b);
    end
    if (cut != 0) send_beat(OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int          base;
    int          pick;
    int          cnt;
    int          cut;
    bit          paused_mid;
    logic [15:0] addr;
    logic [15:0] cont_addr;

    sb         = new();
    paused_mid = 1'b0;
    cont_addr  = 16'h0000;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: end mark and zero count with nothing held.
    send_beat(OP_END, 8'hFF);
    send_beat(OP_BYTE, 8'h00);
    // Run that wraps from FFFF to 0000 and stays in one record.
    send_beat(OP_BYTE, 8'h03);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'hFE);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h80);
    // Address jump flushes the wrapped record.
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, 8'h12);
    send_beat(OP_BYTE, 8'h34);
    send_beat(OP_BYTE, 8'h7F);
    // Next packed record continues the held one.
    send_beat(OP_BYTE, 8'h02);
    send_beat(OP_BYTE, 8'h12);
    send_beat(OP_BYTE, 8'h35);
    send_beat(OP_BYTE, 8'h01);
    send_beat(OP_BYTE, 8'hFE);
    // Largest count, then end of input in the middle of its data.
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h5A);
    send_beat(OP_END, 8'h00);
    wait_drained();

    // Most pairs from one beat: 25 bytes held, then the end mark.
    send_packed(8'd25, 16'($urandom_range(0, 65535)), 28);
    base = sb.beats_taken;

    while (sb.beats_taken - base < RANDOM_BEATS) begin
      quiet_stretch = (sb.beats_taken - base >= 50) && (sb.beats_taken - base < 100);
      if (!paused_mid && sb.beats_taken - base >= 110) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed record, in half the cases continuing on from the last one.
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 60) : $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: addr = cont_addr;
          5, 6:          addr = 16'($urandom_range(0, 65535));
          7:             addr = 16'hFFFF - 16'($urandom_range(0, 5));
          default:       addr = cont_addr + 16'($urandom_range(1, 3));
        endcase
        send_packed(8'(cnt), addr, 0);
        cont_addr = addr + 16'(cnt);
      end else if (pick < 78) begin
        send_beat(OP_BYTE, 8'h00);
      end else if (pick < 86) begin
        send_beat(OP_END, 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        // Broken record: end mark anywhere inside it or right after it.
        cnt  = $urandom_range(1, 30);
        cut  = $urandom_range(1, cnt + 3);
        addr = ($urandom_range(0, 1) == 0) ? cont_addr : 16'($urandom_range(0, 65535));
        send_packed(8'(cnt), addr, cut);
      end else begin
        // Noise: raw bytes with the odd end mark.
        repeat ($urandom_range(1, 4)) begin
          send_beat(($urandom_range(0, 9) == 0) ? OP_END : OP_BYTE,
                    8'($urandom_range(0, 255)));
        end
      end
    end
    quiet_stretch = 1'b0;

    // Drain, then give the block time to show any stray pair.
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d beats; %0d data records and %0d end records predicted.",
             sb.beats_taken, sb.data_records, sb.end_records);
    $display("Checked %0d character pairs, %0d field errors.", sb.pairs_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
